FILE: sv/c_subset_lexer_assert.svh
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSLX_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication, checked out of reset
`define CSLX_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

FILE: sv/cslx_pkg.sv
package cslx_pkg;

    localparam int POSITION_BITS = 16;
    localparam int NUMBER_BITS   = 31;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int CNT_BITS      = 3;

    localparam logic [2:0] KIND_OPERATOR = 3'd0;
    localparam logic [2:0] KIND_IDENT    = 3'd1;
    localparam logic [2:0] KIND_NUMBER   = 3'd2;
    localparam logic [2:0] KIND_KEYWORD  = 3'd3;
    localparam logic [2:0] KIND_EOF      = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    localparam logic [3:0] OP_PLUS  = 4'd0;
    localparam logic [3:0] OP_MINUS = 4'd1;
    localparam logic [3:0] OP_STAR  = 4'd2;
    localparam logic [3:0] OP_SLASH = 4'd3;
    localparam logic [3:0] OP_LPAR  = 4'd4;
    localparam logic [3:0] OP_RPAR  = 4'd5;
    localparam logic [3:0] OP_LT    = 4'd6;
    localparam logic [3:0] OP_GT    = 4'd7;
    localparam logic [3:0] OP_ASSIGN = 4'd8;
    localparam logic [3:0] OP_SEMI  = 4'd9;
    localparam logic [3:0] OP_LBRACE = 4'd10;
    localparam logic [3:0] OP_RBRACE = 4'd11;
    localparam logic [3:0] OP_EQ    = 4'd12;
    localparam logic [3:0] OP_NE    = 4'd13;
    localparam logic [3:0] OP_LE    = 4'd14;
    localparam logic [3:0] OP_GE    = 4'd15;

    localparam logic [2:0] KW_RETURN = 3'd0;
    localparam logic [2:0] KW_IF     = 3'd1;
    localparam logic [2:0] KW_ELSE   = 3'd2;
    localparam logic [2:0] KW_WHILE  = 3'd3;
    localparam logic [2:0] KW_FOR    = 3'd4;
    localparam logic [2:0] KW_NONE   = 3'd7;

    localparam logic [1:0] HELD_LT   = 2'd0;
    localparam logic [1:0] HELD_GT   = 2'd1;
    localparam logic [1:0] HELD_EQ   = 2'd2;
    localparam logic [1:0] HELD_BANG = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [2:0]               token_kind;
        logic [3:0]               operator_code;
        logic [2:0]               keyword_code;
        logic [POSITION_BITS-1:0] start_offset;
        logic [POSITION_BITS-1:0] token_length;
        logic [NUMBER_BITS-1:0]   number_value;
        logic                     number_overflow;
        logic                     last_of_run;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } t_single;

    function automatic logic is_alpha(input logic [7:0] c);
        case (c) inside
            [8'h61:8'h7A], [8'h41:8'h5A]: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        case (c) inside
            [8'h30:8'h39]: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        case (c) inside
            8'h20, [8'h09:8'h0D]: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_single single_op(input logic [7:0] c);
        t_single s;
        s.hit = 1'b1;
        case (c)
            8'h2B: s.code = OP_PLUS;
            8'h2D: s.code = OP_MINUS;
            8'h2A: s.code = OP_STAR;
            8'h2F: s.code = OP_SLASH;
            8'h28: s.code = OP_LPAR;
            8'h29: s.code = OP_RPAR;
            8'h3B: s.code = OP_SEMI;
            8'h7B: s.code = OP_LBRACE;
            8'h7D: s.code = OP_RBRACE;
            default: begin
                s.hit  = 1'b0;
                s.code = OP_PLUS;
            end
        endcase
        return s;
    endfunction

    function automatic logic [3:0] held_single(input logic [1:0] p);
        case (p)
            HELD_LT: return OP_LT;
            HELD_GT: return OP_GT;
            HELD_EQ: return OP_ASSIGN;
            default: return OP_PLUS;
        endcase
    endfunction

    function automatic logic [3:0] held_double(input logic [1:0] p);
        case (p)
            HELD_LT: return OP_LE;
            HELD_GT: return OP_GE;
            HELD_EQ: return OP_EQ;
            default: return OP_NE;
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        case (k)
            KW_RETURN: return 3'd6;
            KW_IF:     return 3'd2;
            KW_ELSE:   return 3'd4;
            KW_WHILE:  return 3'd5;
            KW_FOR:    return 3'd3;
            default:   return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
        logic [47:0] txt;
        case (k)
            KW_RETURN: txt = "return";
            KW_IF:     txt = {"if", 32'h0};
            KW_ELSE:   txt = {"else", 16'h0};
            KW_WHILE:  txt = {"while", 8'h0};
            KW_FOR:    txt = {"for", 24'h0};
            default:   txt = '0;
        endcase
        if (i > 3'd5) begin
            return 8'h00;
        end
        return txt[8 * (5 - int'(i)) +: 8];
    endfunction

    function automatic logic [2:0] kw_first(input logic [7:0] c);
        case (c)
            8'h72:   return KW_RETURN;
            8'h69:   return KW_IF;
            8'h65:   return KW_ELSE;
            8'h77:   return KW_WHILE;
            8'h66:   return KW_FOR;
            default: return KW_NONE;
        endcase
    endfunction

    function automatic t_token make_token(
        input logic [2:0]               kind,
        input logic [3:0]               op,
        input logic [2:0]               kw,
        input logic [POSITION_BITS-1:0] start,
        input logic [POSITION_BITS-1:0] len,
        input logic [NUMBER_BITS-1:0]   val,
        input logic                     ovf
    );
        t_token t;
        t.token_kind      = kind;
        t.operator_code   = op;
        t.keyword_code    = kw;
        t.start_offset    = start;
        t.token_length    = len;
        t.number_value    = val;
        t.number_overflow = ovf;
        t.last_of_run     = 1'b0;
        return t;
    endfunction

endpackage

FILE: sv/cslx_core.sv
module cslx_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  cslx_pkg::t_in  i_item,
    output cslx_pkg::t_push o_push
);
    import cslx_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_OP     = 2'd3
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [1:0]               r_pending, n_pending;
    logic [2:0]               r_track, n_track;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_run, n_run;
    logic [NUMBER_BITS-1:0]   r_acc, n_acc;
    logic                     r_ovf, n_ovf;

    logic [7:0]               c;
    logic                     eot;
    logic                     a_v, b_v;
    t_token                   a_tok, b_tok;
    logic                     trk_live;
    logic [POSITION_BITS-1:0] trk_len;
    logic                     blocked;
    logic [POSITION_BITS-1:0] run_inc;
    logic [NUMBER_BITS+3:0]   prod;
    t_single                  sop;

    assign c        = i_item.text_byte;
    assign eot      = i_item.end_of_text;
    assign trk_live = (r_track <= KW_FOR);
    assign trk_len  = POSITION_BITS'(kw_len(r_track));
    assign blocked  = !eot && (is_digit(c) || c == 8'h5F);
    assign run_inc  = (&r_run) ? r_run : r_run + 1'b1;
    assign prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (NUMBER_BITS + 4)'(c[3:0]);
    assign sop      = single_op(c);

    always_comb begin
        case (r_mode)
            MODE_IDENT: begin
                if (trk_live && r_run == trk_len && !blocked) begin
                    a_tok = make_token(KIND_KEYWORD, OP_PLUS, r_track, r_start, r_run,
                                       '0, 1'b0);
                end else begin
                    a_tok = make_token(KIND_IDENT, OP_PLUS, KW_RETURN, r_start, r_run,
                                       '0, 1'b0);
                end
            end
            MODE_NUMBER: begin
                a_tok = make_token(KIND_NUMBER, OP_PLUS, KW_RETURN, r_start, r_run,
                                   r_acc, r_ovf);
            end
            MODE_OP: begin
                if (r_pending == HELD_BANG) begin
                    a_tok = make_token(KIND_ERROR, OP_PLUS, KW_RETURN, r_start,
                                       POSITION_BITS'(1), '0, 1'b0);
                end else begin
                    a_tok = make_token(KIND_OPERATOR, held_single(r_pending), KW_RETURN,
                                       r_start, POSITION_BITS'(1), '0, 1'b0);
                end
            end
            default: begin
                a_tok = '0;
            end
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        n_track   = r_track;
        n_start   = r_start;
        n_pos     = r_pos;
        n_run     = r_run;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        a_v       = 1'b0;
        b_v       = 1'b0;
        b_tok     = '0;
        if (eot) begin
            a_v       = (r_mode != MODE_IDLE);
            b_v       = 1'b1;
            b_tok     = make_token(KIND_EOF, OP_PLUS, KW_RETURN, r_pos, '0, '0, 1'b0);
            n_mode    = MODE_IDLE;
            n_pending = HELD_LT;
            n_track   = KW_NONE;
            n_start   = '0;
            n_pos     = '0;
            n_run     = '0;
            n_acc     = '0;
            n_ovf     = 1'b0;
        end else begin
            n_pos = r_pos + 1'b1;
            if (r_mode == MODE_OP && c == 8'h3D) begin
                b_v    = 1'b1;
                b_tok  = make_token(KIND_OPERATOR, held_double(r_pending), KW_RETURN,
                                    r_start, POSITION_BITS'(2), '0, 1'b0);
                n_mode = MODE_IDLE;
            end else if (r_mode == MODE_IDENT && is_alpha(c)) begin
                if (trk_live && r_run < trk_len) begin
                    if (kw_char(r_track, r_run[2:0]) != c) begin
                        n_track = KW_NONE;
                    end
                end else if (trk_live) begin
                    n_track = KW_NONE;
                end
                n_run = run_inc;
            end else if (r_mode == MODE_NUMBER && is_digit(c)) begin
                if (prod[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
                    n_acc = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod[NUMBER_BITS-1:0];
                end
                n_run = run_inc;
            end else begin
                a_v    = (r_mode != MODE_IDLE);
                n_mode = MODE_IDLE;
                if (is_space(c)) begin
                    n_mode = MODE_IDLE;
                end else if (is_alpha(c)) begin
                    n_mode  = MODE_IDENT;
                    n_start = r_pos;
                    n_run   = POSITION_BITS'(1);
                    n_track = kw_first(c);
                end else if (is_digit(c)) begin
                    n_mode  = MODE_NUMBER;
                    n_start = r_pos;
                    n_run   = POSITION_BITS'(1);
                    n_acc   = NUMBER_BITS'(c[3:0]);
                    n_ovf   = 1'b0;
                end else if (c == 8'h3C || c == 8'h3E || c == 8'h3D || c == 8'h21) begin
                    n_mode  = MODE_OP;
                    n_start = r_pos;
                    case (c)
                        8'h3C:   n_pending = HELD_LT;
                        8'h3E:   n_pending = HELD_GT;
                        8'h3D:   n_pending = HELD_EQ;
                        default: n_pending = HELD_BANG;
                    endcase
                end else if (sop.hit) begin
                    b_v   = 1'b1;
                    b_tok = make_token(KIND_OPERATOR, sop.code, KW_RETURN, r_pos,
                                       POSITION_BITS'(1), '0, 1'b0);
                end else begin
                    b_v   = 1'b1;
                    b_tok = make_token(KIND_ERROR, OP_PLUS, KW_RETURN, r_pos,
                                       POSITION_BITS'(1), '0, 1'b0);
                end
            end
        end
    end

    always_comb begin
        o_push       = '0;
        o_push.tok0  = a_v ? a_tok : b_tok;
        o_push.tok1  = b_tok;
        if (i_fire) begin
            if (a_v && b_v) begin
                o_push.count            = 2'd2;
                o_push.tok1.last_of_run = 1'b1;
            end else if (a_v || b_v) begin
                o_push.count            = 2'd1;
                o_push.tok0.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_pending <= HELD_LT;
            r_track   <= KW_NONE;
            r_start   <= '0;
            r_pos     <= '0;
            r_run     <= '0;
            r_acc     <= '0;
            r_ovf     <= 1'b0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_track   <= n_track;
            r_start   <= n_start;
            r_pos     <= n_pos;
            r_run     <= n_run;
            r_acc     <= n_acc;
            r_ovf     <= n_ovf;
        end
    end

endmodule

FILE: sv/cslx_fifo.sv
`include "c_subset_lexer_assert.svh"

module cslx_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cslx_pkg::t_push  i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output cslx_pkg::t_token o_token
);
    import cslx_pkg::*;

    t_token                   r_slot [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_head, r_tail;
    logic [CNT_BITS-1:0]      r_count;
    logic                     pop;

    assign o_valid = (r_count != '0);
    assign o_token = r_slot[r_head];
    assign o_room  = (r_count <= CNT_BITS'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + FIFO_PTR_BITS'(pop);
            r_tail  <= r_tail + FIFO_PTR_BITS'(i_push.count);
            r_count <= r_count + CNT_BITS'(i_push.count) - CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_slot[r_tail] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_slot[r_tail + 1'b1] <= i_push.tok1;
        end
    end

    `CSLX_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_BITS'(FIFO_DEPTH))
    `CSLX_ASSERT_IMPL(a_push_room, i_push.count != 2'd0, o_room)
    `CSLX_ASSERT_NEXT(a_hold_head, o_valid && !i_ready, o_valid && $stable(r_head))

endmodule

FILE: sv/c_subset_lexer.sv
// Path: an accepted item is held in the input register and lexed once the result queue has
// room; its tokens are written to the queue and offered from there.
// Throughput: one item per cycle while the queue has room; the four-entry result queue
// absorbs items that yield two tokens, and a long run of them is limited by the
// single-token output port.
// Reset (synchronous, active low) empties the queue and returns the scanner to idle at offset 0.
module c_subset_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cslx_pkg::t_in    i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output cslx_pkg::t_token o_token
);
    import cslx_pkg::*;

    logic  r_in_valid;
    t_in   r_in;
    logic  room;
    logic  fire;
    t_push push;

    assign fire    = r_in_valid && room;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_item;
        end
    end

    cslx_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_push  (push)
    );

    cslx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_token (o_token)
    );

endmodule
